[rtl/shifting_insert_remove_array_assert.svh]
// Assertion macros used by the top RTL file of the slot array.
// Each use names a label, a property or condition, and a message string.
// The module that uses them must have i_clk and i_rst_n in scope.
`ifndef SHIFTING_INSERT_REMOVE_ARRAY_ASSERT_SVH
`define SHIFTING_INSERT_REMOVE_ARRAY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every clock edge outside reset.
`define SIRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks a plain condition at every clock edge outside reset.
`define SIRA_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`else

`define SIRA_ASSERT(lbl, prop, msg)
`define SIRA_ASSERT_NOW(lbl, cond, msg)

`endif

`endif

[rtl/sira_pkg.sv]
`default_nettype none

package sira_pkg;

    // Field widths and defaults.
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 8;
    localparam int DEFAULT_DEPTH = 64;

    // Marker held by an empty slot.
    localparam logic signed [VALUE_W-1:0] EMPTY_MARK = -32'sd66;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_EXISTS = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_EXISTS = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_APPLY    = 2'd1,
        S_DUMP     = 2'd2,
        S_DUMP_END = 2'd3
    } t_state;

    // Operation broadcast to every cell.
    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_CAPTURE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_REMOVE  = 3'd3,
        OP_ROTATE  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tgt_occ;
        logic     clamped;
    } t_cell_ctrl;

    // A slot counts as occupied when its value is not negative.
    function automatic logic is_occupied(input logic signed [VALUE_W-1:0] v);
        return !v[VALUE_W-1];
    endfunction

endpackage

`default_nettype wire

[rtl/sira_cell.sv]
`default_nettype none

module sira_cell #(
    parameter int DEPTH = sira_pkg::DEFAULT_DEPTH,
    parameter int IDX   = 0,
    parameter int CW    = sira_pkg::POS_W
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire sira_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic [CW-1:0]                        i_pos,
    input  wire logic signed [sira_pkg::VALUE_W-1:0]  i_value,
    input  wire logic signed [sira_pkg::VALUE_W-1:0]  i_left,
    input  wire logic signed [sira_pkg::VALUE_W-1:0]  i_right,
    output logic signed [sira_pkg::VALUE_W-1:0]       o_slot,
    output logic                                      o_hit,
    output logic                                      o_match
);

    localparam logic [CW-1:0] MY_IDX     = CW'(IDX);
    localparam logic [CW-1:0] LAST_IDX   = CW'(DEPTH - 1);
    localparam logic [CW-1:0] SECOND_IDX = CW'(DEPTH - 2);

    logic signed [sira_pkg::VALUE_W-1:0] r_slot;
    logic signed [sira_pkg::VALUE_W-1:0] n_slot;
    logic                                r_hit;
    logic                                r_match;
    logic [CW-1:0]                       w_tgt;

    // Insert target after clamping to the last slot.
    assign w_tgt = i_ctrl.clamped ? LAST_IDX : i_pos;

    // Next slot value from the broadcast operation and the neighbors.
    always_comb begin
        n_slot = r_slot;
        case (i_ctrl.op)
            sira_pkg::OP_INSERT: begin
                if (i_ctrl.clamped && (MY_IDX == SECOND_IDX)) begin
                    n_slot = i_right;
                end else if (MY_IDX == w_tgt) begin
                    n_slot = i_value;
                end else if (i_ctrl.tgt_occ && !i_ctrl.clamped && (MY_IDX > w_tgt)) begin
                    n_slot = i_left;
                end
            end
            sira_pkg::OP_REMOVE: begin
                if (MY_IDX == LAST_IDX) begin
                    n_slot = sira_pkg::EMPTY_MARK;
                end else if (MY_IDX >= i_pos) begin
                    n_slot = i_right;
                end
            end
            sira_pkg::OP_ROTATE: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    // Slot register and the flags captured when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= sira_pkg::EMPTY_MARK;
            r_hit   <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (i_ctrl.op == sira_pkg::OP_CAPTURE) begin
                r_hit   <= (MY_IDX == i_pos) && sira_pkg::is_occupied(r_slot);
                r_match <= (r_slot == i_value);
            end
        end
    end

    assign o_slot  = r_slot;
    assign o_hit   = r_hit;
    assign o_match = r_match;

endmodule

`default_nettype wire

[rtl/shifting_insert_remove_array.sv]
// Insert, remove and exists: the accept cycle captures per-cell flags, then the apply
// state applies the shift or, for exists, loads the answer once the output is free.
// The exists answer is registered in the output stage; the apply state waits while the output is stalled.
// A dump runs the accept cycle, DEPTH rotate steps and a closing state that loads the
// final result; output stalls can hold the rotate steps and the closing state.
// Reset is synchronous and active low; every slot loads the empty marker at once.
`default_nettype none

`include "shifting_insert_remove_array_assert.svh"

module shifting_insert_remove_array #(
    parameter int DEPTH = sira_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_command,
    input  wire logic signed [sira_pkg::VALUE_W-1:0]  i_item_value,
    input  wire logic [sira_pkg::POS_W-1:0]           i_slot_position,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [1:0]                                o_result_kind,
    output logic signed [sira_pkg::VALUE_W-1:0]       o_entry_value,
    output logic                                      o_found,
    output logic                                      o_last
);

    localparam int CW    = ($clog2(DEPTH) > sira_pkg::POS_W) ? $clog2(DEPTH) : sira_pkg::POS_W;
    localparam int CNT_W = $clog2(DEPTH);
    localparam logic [CW-1:0]    LAST_IDX = CW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH - 1);

    sira_pkg::t_state                    r_state;
    sira_pkg::t_state                    n_state;
    sira_pkg::t_cmd                      r_cmd;
    logic [CW-1:0]                       r_pos;
    logic signed [sira_pkg::VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]                    r_cnt;
    logic signed [sira_pkg::VALUE_W-1:0] r_pend;
    logic                                r_pend_valid;
    logic                                r_out_valid;
    sira_pkg::t_kind                     r_out_kind;
    logic signed [sira_pkg::VALUE_W-1:0] r_out_value;
    logic                                r_out_found;
    logic                                r_out_last;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_load;
    logic                                w_step;
    logic                                w_need_emit;
    logic                                w_head_occ;
    sira_pkg::t_kind                     w_out_kind;
    logic signed [sira_pkg::VALUE_W-1:0] w_out_value;
    logic                                w_out_found;
    logic                                w_out_last;
    sira_pkg::t_cell_ctrl                w_ctrl;
    logic [CW-1:0]                       w_cell_pos;
    logic signed [sira_pkg::VALUE_W-1:0] w_cell_value;
    logic signed [sira_pkg::VALUE_W-1:0] w_slot [DEPTH];
    logic [DEPTH-1:0]                    w_hit;
    logic [DEPTH-1:0]                    w_match;

    // Handshake helpers.
    assign o_stall     = (r_state != sira_pkg::S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_head_occ  = sira_pkg::is_occupied(w_slot[0]);
    assign w_need_emit = w_head_occ && r_pend_valid;

    // Cells see the incoming request while idle and the held one afterwards.
    assign w_cell_pos   = (r_state == sira_pkg::S_IDLE) ? CW'(i_slot_position) : r_pos;
    assign w_cell_value = (r_state == sira_pkg::S_IDLE) ? i_item_value : r_value;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sira_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (sira_pkg::t_cmd'(i_command) == sira_pkg::CMD_DUMP) begin
                        n_state = sira_pkg::S_DUMP;
                    end else begin
                        n_state = sira_pkg::S_APPLY;
                    end
                end
            end
            sira_pkg::S_APPLY: begin
                if ((r_cmd != sira_pkg::CMD_EXISTS) || w_out_free) begin
                    n_state = sira_pkg::S_IDLE;
                end
            end
            sira_pkg::S_DUMP: begin
                if ((!w_need_emit || w_out_free) && (r_cnt == CNT_LAST)) begin
                    n_state = sira_pkg::S_DUMP_END;
                end
            end
            sira_pkg::S_DUMP_END: begin
                if (w_out_free) begin
                    n_state = sira_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sira_pkg::S_IDLE;
            end
        endcase
    end

    // Cell operation, dump stepping and output loading.
    always_comb begin
        w_ctrl.op      = sira_pkg::OP_HOLD;
        w_ctrl.tgt_occ = |w_hit;
        w_ctrl.clamped = (r_pos >= LAST_IDX);
        w_load         = 1'b0;
        w_step         = 1'b0;
        w_out_kind     = sira_pkg::KIND_EXISTS;
        w_out_value    = '0;
        w_out_found    = 1'b0;
        w_out_last     = 1'b0;
        case (r_state)
            sira_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.op = sira_pkg::OP_CAPTURE;
                end
            end
            sira_pkg::S_APPLY: begin
                case (r_cmd)
                    sira_pkg::CMD_INSERT: w_ctrl.op = sira_pkg::OP_INSERT;
                    sira_pkg::CMD_REMOVE: w_ctrl.op = sira_pkg::OP_REMOVE;
                    sira_pkg::CMD_EXISTS: begin
                        w_load      = w_out_free;
                        w_out_kind  = sira_pkg::KIND_EXISTS;
                        w_out_found = |w_match;
                        w_out_last  = 1'b1;
                    end
                    default: w_ctrl.op = sira_pkg::OP_HOLD;
                endcase
            end
            sira_pkg::S_DUMP: begin
                // An entry leaves only once a later one is known to exist.
                w_step = !w_need_emit || w_out_free;
                if (w_step) begin
                    w_ctrl.op = sira_pkg::OP_ROTATE;
                end
                w_load      = w_step && w_need_emit;
                w_out_kind  = sira_pkg::KIND_ENTRY;
                w_out_value = r_pend;
            end
            sira_pkg::S_DUMP_END: begin
                w_load     = w_out_free;
                w_out_last = 1'b1;
                if (r_pend_valid) begin
                    w_out_kind  = sira_pkg::KIND_ENTRY;
                    w_out_value = r_pend;
                end else begin
                    w_out_kind = sira_pkg::KIND_NONE;
                end
            end
            default: begin
                w_ctrl.op = sira_pkg::OP_HOLD;
            end
        endcase
    end

    // Control and request registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sira_pkg::S_IDLE;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cmd        <= sira_pkg::t_cmd'(i_command);
                r_pos        <= CW'(i_slot_position);
                r_value      <= i_item_value;
                r_pend_valid <= 1'b0;
            end
            if (w_step) begin
                r_cnt <= (r_cnt == CNT_LAST) ? '0 : r_cnt + 1'b1;
                if (w_head_occ) begin
                    r_pend       <= w_slot[0];
                    r_pend_valid <= 1'b1;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= w_out_kind;
                r_out_value <= w_out_value;
                r_out_found <= w_out_found;
                r_out_last  <= w_out_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The chain of slot cells; the top cell wraps to the bottom for dumps.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [sira_pkg::VALUE_W-1:0] w_left;
        logic signed [sira_pkg::VALUE_W-1:0] w_right;

        if (g == 0) begin : g_bottom
            assign w_left = sira_pkg::EMPTY_MARK;
        end else begin : g_lower
            assign w_left = w_slot[g-1];
        end

        if (g == DEPTH - 1) begin : g_top
            assign w_right = w_slot[0];
        end else begin : g_upper
            assign w_right = w_slot[g+1];
        end

        sira_cell #(
            .DEPTH (DEPTH),
            .IDX   (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_pos   (w_cell_pos),
            .i_value (w_cell_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_slot  (w_slot[g]),
            .o_hit   (w_hit[g]),
            .o_match (w_match[g])
        );
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_entry_value = r_out_value;
    assign o_found       = r_out_found;
    assign o_last        = r_out_last;

    // A taken request always leaves the idle state.
    `SIRA_ASSERT(a_accept_busy, (w_accept |=> (r_state != sira_pkg::S_IDLE)),
        "request taken but controller stayed idle")
    // At most one cell can be the insert target.
    `SIRA_ASSERT_NOW(a_hit_onehot, $onehot0(w_hit), "more than one target cell flagged")
    // A result never overwrites one that is still waiting.
    `SIRA_ASSERT_NOW(a_load_free, (!w_load || !r_out_valid || !i_stall),
        "result loaded over a stalled result")
    // The dump counter rests at zero outside a dump.
    `SIRA_ASSERT_NOW(a_cnt_rest, ((r_state == sira_pkg::S_DUMP) || (r_cnt == '0)),
        "dump counter not at rest")
    // Only an exists query loads a result from the apply state.
    `SIRA_ASSERT_NOW(a_apply_exists,
        (!(w_load && (r_state == sira_pkg::S_APPLY)) || (r_cmd == sira_pkg::CMD_EXISTS)),
        "apply state loaded a result for a non-query request")

endmodule

`default_nettype wire
